### rtl/core/fne_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fne_pkg
// Shared types, constants and fixed-point helpers for the FitzHugh-Nagumo
// Euler step pipeline (signed Q8.24, saturating).
// ----------------------------------------------------------------------------
package fne_pkg;

  localparam int WORD_W     = 32;
  localparam int FRAC_W     = 24;
  localparam int PROD_W     = 2 * WORD_W;
  localparam int STEP_W     = WORD_W - 1;
  localparam int ADDR_W     = 4;
  localparam int NUM_STAGES = 9;

  typedef logic signed [WORD_W-1:0]        word_t;
  typedef logic signed [WORD_W:0]          wide_t;
  typedef logic signed [PROD_W-1:0]        prod_t;
  typedef logic signed [PROD_W-FRAC_W-1:0] shifted_t;
  typedef logic        [STEP_W-1:0]        step_t;

  localparam word_t WORD_MAX   = {1'b0, {(WORD_W-1){1'b1}}};
  localparam word_t WORD_MIN   = {1'b1, {(WORD_W-1){1'b0}}};
  localparam word_t FX_ONE     = word_t'(64'sd1 <<< FRAC_W);
  localparam prod_t ROUND_BIAS = prod_t'(64'sd1 <<< (FRAC_W - 1));

  // reset values of the configuration registers (Q8.24)
  localparam step_t TIME_STEP_RST     = step_t'(167772);
  localparam word_t CUBIC_OFFSET_RST  = word_t'(-1677722);
  localparam word_t RECOVERY_GAIN_RST = word_t'(50331648);
  localparam word_t RECOVERY_RATE_RST = word_t'(83886);

  typedef enum logic [1:0] {
    REG_TIME_STEP     = 2'd0,
    REG_CUBIC_OFFSET  = 2'd1,
    REG_RECOVERY_GAIN = 2'd2,
    REG_RECOVERY_RATE = 2'd3
  } reg_idx_t;

  function automatic word_t sat_word(wide_t s);
    if (s[WORD_W] != s[WORD_W-1]) begin
      return s[WORD_W] ? WORD_MIN : WORD_MAX;
    end
    return word_t'(s[WORD_W-1:0]);
  endfunction

  function automatic word_t sat_add(word_t a, word_t b);
    wide_t s;
    s = wide_t'(a) + wide_t'(b);
    return sat_word(s);
  endfunction

  function automatic word_t sat_sub(word_t a, word_t b);
    wide_t s;
    s = wide_t'(a) - wide_t'(b);
    return sat_word(s);
  endfunction

  // round to nearest (ties up), drop fraction bits, saturate to a word
  function automatic word_t fx_round(prod_t p);
    prod_t    r;
    shifted_t q;
    r = p + ROUND_BIAS;
    q = shifted_t'(r[PROD_W-1:FRAC_W]);
    if (!(&q[PROD_W-FRAC_W-1:WORD_W-1]) && (|q[PROD_W-FRAC_W-1:WORD_W-1])) begin
      return q[PROD_W-FRAC_W-1] ? WORD_MIN : WORD_MAX;
    end
    return word_t'(q[WORD_W-1:0]);
  endfunction

  function automatic prod_t fx_mul_raw(word_t a, word_t b);
    return prod_t'(a) * prod_t'(b);
  endfunction

endpackage

### rtl/core/fne_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fne_cfg
// APB register file holding dt, alpha, gamma and epsilon.
// ----------------------------------------------------------------------------
module fne_cfg (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [fne_pkg::ADDR_W-1:0]  paddr,
  input  logic [fne_pkg::WORD_W-1:0]  pwdata,
  output logic [fne_pkg::WORD_W-1:0]  prdata,
  output logic                        pready,
  output fne_pkg::step_t              time_step,
  output fne_pkg::word_t              cubic_offset,
  output fne_pkg::word_t              recovery_gain,
  output fne_pkg::word_t              recovery_rate
);
  import fne_pkg::*;

  reg_idx_t idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      time_step     <= TIME_STEP_RST;
      cubic_offset  <= CUBIC_OFFSET_RST;
      recovery_gain <= RECOVERY_GAIN_RST;
      recovery_rate <= RECOVERY_RATE_RST;
    end else if (wr_en) begin
      case (idx)
        REG_TIME_STEP:     time_step     <= step_t'(pwdata[STEP_W-1:0]);
        REG_CUBIC_OFFSET:  cubic_offset  <= word_t'(pwdata);
        REG_RECOVERY_GAIN: recovery_gain <= word_t'(pwdata);
        REG_RECOVERY_RATE: recovery_rate <= word_t'(pwdata);
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_TIME_STEP:     prdata = {1'b0, time_step};
      REG_CUBIC_OFFSET:  prdata = cubic_offset;
      REG_RECOVERY_GAIN: prdata = recovery_gain;
      REG_RECOVERY_RATE: prdata = recovery_rate;
      default:           prdata = '0;
    endcase
  end

endmodule

### rtl/core/fitzhugh_nagumo_euler_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fitzhugh_nagumo_euler_step
// Forward-Euler FitzHugh-Nagumo cell update, signed Q8.24 with saturation.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one cell volume per transaction:
//   v_old, h_old, v_star, h_star, stim. Output channel (out_valid/out_ready)
//   returns v_new, h_new for each volume, in order.
//   Throughput is one volume per cycle while the receiver does not stall; the
//   stages form a 9-deep pipeline of 32x32 multiplies, roundings and
//   saturating adds.
//   When the receiver stalls, the output register holds; upstream stages keep
//   filling empty slots, and in_ready drops only once all 9 stages are full.
//   Reset (rst, synchronous) empties the pipeline and loads the register
//   defaults: dt 0.01, alpha -0.1, gamma 3.0, epsilon 0.005.
//   Registers sit on the APB port at 0x0 (dt), 0x4 (alpha), 0x8 (gamma),
//   0xC (epsilon); write them only while the pipeline is empty.
// ----------------------------------------------------------------------------
module fitzhugh_nagumo_euler_step (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  fne_pkg::word_t              v_old,
  input  fne_pkg::word_t              h_old,
  input  fne_pkg::word_t              v_star,
  input  fne_pkg::word_t              h_star,
  input  fne_pkg::word_t              stim,
  output logic                        out_valid,
  input  logic                        out_ready,
  output fne_pkg::word_t              v_new,
  output fne_pkg::word_t              h_new,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [fne_pkg::ADDR_W-1:0]  paddr,
  input  logic [fne_pkg::WORD_W-1:0]  pwdata,
  output logic [fne_pkg::WORD_W-1:0]  prdata,
  output logic                        pready
);
  import fne_pkg::*;

  step_t time_step;
  word_t cubic_offset, recovery_gain, recovery_rate;
  word_t dt;

  fne_cfg u_cfg (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .time_step     (time_step),
    .cubic_offset  (cubic_offset),
    .recovery_gain (recovery_gain),
    .recovery_rate (recovery_rate)
  );

  assign dt = word_t'({1'b0, time_step});

  logic [NUM_STAGES-1:0] vld;
  logic [NUM_STAGES-1:0] ld;

  // a stage loads when empty or when its contents move on
  always_comb begin
    ld[NUM_STAGES-1] = !vld[NUM_STAGES-1] || out_ready;
    for (int i = NUM_STAGES - 2; i >= 0; i--) begin
      ld[i] = !vld[i] || ld[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (ld[0]) begin
        vld[0] <= in_valid;
      end
      for (int i = 1; i < NUM_STAGES; i++) begin
        if (ld[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  assign in_ready  = ld[0];
  assign out_valid = vld[NUM_STAGES-1];

  // stage 1: differences, gamma*h_old
  word_t s1_vo, s1_vs, s1_hs, s1_st, s1_a, s1_b;
  prod_t s1_pg;
  always_ff @(posedge clk) begin
    if (ld[0] && in_valid) begin
      s1_vo <= v_old;
      s1_vs <= v_star;
      s1_hs <= h_star;
      s1_st <= stim;
      s1_a  <= sat_sub(v_star, cubic_offset);
      s1_b  <= sat_sub(FX_ONE, v_star);
      s1_pg <= fx_mul_raw(recovery_gain, h_old);
    end
  end

  // stage 2: vs*a, round gamma*ho
  word_t s2_vo, s2_vs, s2_hs, s2_st, s2_b, s2_g;
  prod_t s2_pv;
  always_ff @(posedge clk) begin
    if (ld[1] && vld[0]) begin
      s2_vo <= s1_vo;
      s2_vs <= s1_vs;
      s2_hs <= s1_hs;
      s2_st <= s1_st;
      s2_b  <= s1_b;
      s2_g  <= fx_round(s1_pg);
      s2_pv <= fx_mul_raw(s1_vs, s1_a);
    end
  end

  // stage 3: round vs*a, vo - gamma*ho
  word_t s3_vs, s3_hs, s3_st, s3_b, s3_p1, s3_e;
  always_ff @(posedge clk) begin
    if (ld[2] && vld[1]) begin
      s3_vs <= s2_vs;
      s3_hs <= s2_hs;
      s3_st <= s2_st;
      s3_b  <= s2_b;
      s3_p1 <= fx_round(s2_pv);
      s3_e  <= sat_sub(s2_vo, s2_g);
    end
  end

  // stage 4: cubic product and epsilon product
  word_t s4_vs, s4_hs, s4_st;
  prod_t s4_pc, s4_pe;
  always_ff @(posedge clk) begin
    if (ld[3] && vld[2]) begin
      s4_vs <= s3_vs;
      s4_hs <= s3_hs;
      s4_st <= s3_st;
      s4_pc <= fx_mul_raw(s3_p1, s3_b);
      s4_pe <= fx_mul_raw(recovery_rate, s3_e);
    end
  end

  // stage 5: round both
  word_t s5_vs, s5_hs, s5_st, s5_c, s5_dh;
  always_ff @(posedge clk) begin
    if (ld[4] && vld[3]) begin
      s5_vs <= s4_vs;
      s5_hs <= s4_hs;
      s5_st <= s4_st;
      s5_c  <= fx_round(s4_pc);
      s5_dh <= fx_round(s4_pe);
    end
  end

  // stage 6: dV, dt*dh
  word_t s6_vs, s6_hs, s6_dv;
  prod_t s6_ph;
  always_ff @(posedge clk) begin
    if (ld[5] && vld[4]) begin
      s6_vs <= s5_vs;
      s6_hs <= s5_hs;
      s6_dv <= sat_add(sat_sub(s5_c, s5_hs), s5_st);
      s6_ph <= fx_mul_raw(dt, s5_dh);
    end
  end

  // stage 7: dt*dV, round dt*dh
  word_t s7_vs, s7_hs, s7_hm;
  prod_t s7_pm;
  always_ff @(posedge clk) begin
    if (ld[6] && vld[5]) begin
      s7_vs <= s6_vs;
      s7_hs <= s6_hs;
      s7_hm <= fx_round(s6_ph);
      s7_pm <= fx_mul_raw(dt, s6_dv);
    end
  end

  // stage 8: round dt*dV, h update
  word_t s8_vs, s8_m, s8_hn;
  always_ff @(posedge clk) begin
    if (ld[7] && vld[6]) begin
      s8_vs <= s7_vs;
      s8_m  <= fx_round(s7_pm);
      s8_hn <= sat_add(s7_hs, s7_hm);
    end
  end

  // stage 9: output register
  always_ff @(posedge clk) begin
    if (ld[8] && vld[7]) begin
      v_new <= sat_add(s8_vs, s8_m);
      h_new <= s8_hn;
    end
  end

  // in_ready low only with a full pipeline and a stalled receiver
  a_full_when_blocked: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> ((&vld) && !out_ready))
    else $error("input blocked while pipeline has room");

  a_accept_fills_s1: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> vld[0])
    else $error("accepted transaction not captured in stage 1");

  a_reset_empties: assert property (@(posedge clk)
    rst |=> (vld == '0))
    else $error("pipeline not empty after reset");

  a_no_drop: assert property (@(posedge clk) disable iff (rst)
    (vld[NUM_STAGES-2] && !ld[NUM_STAGES-1]) |=> vld[NUM_STAGES-2])
    else $error("stage 8 contents lost during stall");

endmodule
